// ----- src/wsr_pkg.sv -----
// ----------------------------------------------------------------------------
// wsr_pkg
// Shared types and constants of the weight stability recorder.
// ----------------------------------------------------------------------------
`default_nettype none

package wsr_pkg;

	localparam int WEIGHT_W = 24;
	localparam int TIME_W   = 32;
	localparam int THR_W    = 23;
	localparam int TOL_W    = 23;
	localparam int DUR_W    = 32;
	localparam int CFG_W    = 32;
	localparam int IDX_W    = 2;
	localparam int PHASE_W  = 2;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 32;

	localparam logic [THR_W-1:0] THR_RST = THR_W'(1000);
	localparam logic [TOL_W-1:0] TOL_RST = TOL_W'(50);
	localparam logic [DUR_W-1:0] DUR_RST = DUR_W'(2000);

	typedef enum logic [IDX_W-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_TOLERANCE = 2'd1,
		REG_DURATION  = 2'd2
	} reg_idx_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE = 2'd0,
		PH_STAB = 2'd1,
		PH_REC  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [THR_W-1:0] threshold;
		logic [TOL_W-1:0] tolerance;
		logic [DUR_W-1:0] duration;
	} cfg_t;

	typedef struct packed {
		logic                       record;
		logic signed [WEIGHT_W-1:0] recorded_weight;
		logic [PHASE_W-1:0]         phase_out;
	} result_t;

endpackage

`default_nettype wire

// ----- src/wsr_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// wsr_cfg_regs
// Configuration registers: threshold, tolerance and duration.
// ----------------------------------------------------------------------------
`default_nettype none

module wsr_cfg_regs (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [wsr_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [wsr_pkg::CFG_W-1:0] cfg_wdata,
	output wsr_pkg::cfg_t                  cfg
);
	import wsr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= THR_RST;
			cfg_q.tolerance <= TOL_RST;
			cfg_q.duration  <= DUR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: cfg_q.threshold <= cfg_wdata[THR_W-1:0];
				REG_TOLERANCE: cfg_q.tolerance <= cfg_wdata[TOL_W-1:0];
				REG_DURATION:  cfg_q.duration  <= cfg_wdata[DUR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- src/wsr_core.sv -----
// ----------------------------------------------------------------------------
// wsr_core
// Phase state machine with candidate weight and start time.
// ----------------------------------------------------------------------------
`default_nettype none

module wsr_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              step,
	input  wire logic signed [wsr_pkg::WEIGHT_W-1:0] weight,
	input  wire logic [wsr_pkg::TIME_W-1:0]        now_ms,
	input  wire wsr_pkg::cfg_t                     cfg,
	output wsr_pkg::result_t                       res
);
	import wsr_pkg::*;

	phase_t                     phase_q, phase_d;
	logic signed [WEIGHT_W-1:0] cand_q, cand_d;
	logic [TIME_W-1:0]          start_q, start_d;

	logic signed [WEIGHT_W:0] w_ext;
	logic signed [WEIGHT_W:0] diff;
	logic [WEIGHT_W:0]        adiff;
	logic                     non_pos;
	logic                     at_thr;
	logic                     in_band;
	logic                     timed_out;
	logic [TIME_W-1:0]        elapsed;

	assign w_ext     = {weight[WEIGHT_W-1], weight};
	assign non_pos   = weight[WEIGHT_W-1] || (weight == '0);
	assign at_thr    = w_ext >= $signed({2'b00, cfg.threshold});
	assign diff      = w_ext - {cand_q[WEIGHT_W-1], cand_q};
	assign adiff     = diff[WEIGHT_W] ? (WEIGHT_W+1)'(-diff) : diff;
	assign in_band   = adiff <= {2'b00, cfg.tolerance};
	assign elapsed   = now_ms - start_q;
	assign timed_out = elapsed >= cfg.duration;

	always_comb begin
		phase_d = phase_q;
		cand_d  = cand_q;
		start_d = start_q;
		if (non_pos) begin
			phase_d = PH_IDLE;
			cand_d  = '0;
			start_d = '0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (at_thr) begin
						phase_d = PH_STAB;
						cand_d  = weight;
						start_d = now_ms;
					end
				end
				PH_STAB: begin
					if (!in_band) begin
						cand_d  = weight;
						start_d = now_ms;
					end else if (timed_out) begin
						if (at_thr) begin
							phase_d = PH_REC;
						end else begin
							cand_d  = weight;
							start_d = now_ms;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		res.phase_out       = phase_d;
		res.record          = (phase_q == PH_STAB) && (phase_d == PH_REC);
		res.recorded_weight = res.record ? weight : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cand_q  <= '0;
			start_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			cand_q  <= cand_d;
			start_q <= start_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/weight_stability_recorder_unit.sv -----
// ----------------------------------------------------------------------------
// weight_stability_recorder_unit
// Records a weight once it has stayed within a band for a set time.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                       | tuser
// s_axis  | in  | weight[23:0], now_ms[55:24]              | -
// m_axis  | out | recorded_weight[23:0], phase_out[25:24]  | record[0]
// cfg     | in  | cfg_index selects, cfg_wdata holds value | -
//
// One word per cycle sustained while m_axis accepts words.
// Input register, then state machine logic, then result register.
// State update occurs as a word moves from input to result register.
// Stalls on m_axis hold both registers; s_tready falls only when both full.
// Reset clears phase, candidate, start time and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module weight_stability_recorder_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [wsr_pkg::IN_DATA_W-1:0]  s_tdata,   // weight, now_ms
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [wsr_pkg::OUT_DATA_W-1:0]      m_tdata,   // recorded_weight, phase_out
	output logic [0:0]                          m_tuser,   // record
	input  wire logic                           cfg_we,
	input  wire logic [wsr_pkg::IDX_W-1:0]      cfg_index,
	input  wire logic [wsr_pkg::CFG_W-1:0]      cfg_wdata
);
	import wsr_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t out_q;

	logic                       valid_s1;
	logic signed [WEIGHT_W-1:0] weight_s1;
	logic [TIME_W-1:0]          now_s1;
	logic                       out_valid_q;
	logic                       out_free;
	logic                       advance;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	wsr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	wsr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.weight (weight_s1),
		.now_ms (now_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			weight_s1 <= s_tdata[WEIGHT_W-1:0];
			now_s1    <= s_tdata[WEIGHT_W +: TIME_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-WEIGHT_W-PHASE_W){1'b0}}, out_q.phase_out,
		out_q.recorded_weight};
	assign m_tuser  = out_q.record;

endmodule

`default_nettype wire

// ----- src/wsr_checker.sv -----
// ----------------------------------------------------------------------------
// wsr_checker
// Port-level checks of the weight stability recorder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module wsr_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [wsr_pkg::OUT_DATA_W-1:0] m_tdata,
	input wire logic [0:0]                     m_tuser
);
	import wsr_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	a_rec_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[25:24] == PH_REC)
		else $error("record without recorded phase");

	a_rec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[23:0] == '0)
		else $error("weight nonzero without record");

	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[25:24] == PH_IDLE || m_tdata[25:24] == PH_STAB ||
			m_tdata[25:24] == PH_REC)
		else $error("unreachable phase code");

endmodule

bind weight_stability_recorder_unit wsr_checker u_wsr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
